// ===== design/refcounted_slot_table_assert.svh =====
// ============================================================================
// refcounted_slot_table assertion macros
// shared assertion forms, clocked on clk and disabled while rst_n is low
// ============================================================================
`ifndef REFCOUNTED_SLOT_TABLE_ASSERT_SVH
`define REFCOUNTED_SLOT_TABLE_ASSERT_SVH

// same-cycle implication
`define RCST_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slot table assertion failed");

// next-cycle implication
`define RCST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slot table assertion failed");

`endif

// ===== design/rcst_pkg.sv =====
// ============================================================================
// rcst_pkg
// command and status codes and the classified request passed front to back
// ============================================================================
package rcst_pkg;

    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_ADD     = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;
    localparam logic [1:0] CMD_LINK    = 2'd3;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_RANGE  = 3'd1;
    localparam logic [2:0] ST_UNUSED = 3'd2;
    localparam logic [2:0] ST_FULL   = 3'd3;
    localparam logic [2:0] ST_SAT    = 3'd4;

    typedef struct packed {
        logic [1:0] cmd;
        logic       a_ok;
        logic       b_ok;
        logic [6:0] slot_a;
        logic [6:0] slot_b;
    } op_t;

endpackage

// ===== design/refcounted_slot_table.sv =====
// ============================================================================
// refcounted_slot_table
// table of reference-counted slots with parent links and release cascade
// ============================================================================
// requests (cmd, slot_a, slot_b) enter on in_valid/in_ready; one result
// (status, slot_index, freed_count, ref_count) per request leaves on
// out_valid/out_ready, in request order
// the back end takes one request at a time, and its path depends on the
// command: a range error on slot_a reads no slot, add or an unused slot
// reads slot a, link reads slot a and then slot b, release reads slot a
// and then each parent visited up the chain, and allocate scans up from
// slot 0 to the lowest free slot, or over all slots when the table is full
// the rate is set by the single-port slot memory: one dependent read a cycle
// a two-entry queue sits between the front and the back end
// after reset the slot memory is cleared, one slot a cycle, with in_ready
// low; then all slots are free
// when out_ready is low the result holds in the output register, the back
// end holds its next result, and the queue takes up to two more requests
// ============================================================================
module refcounted_slot_table
#(
    parameter int SLOTS      = 64,
    parameter int COUNT_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [6:0]  slot_a,
    input  logic [6:0]  slot_b,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [5:0]  slot_index,
    output logic [6:0]  freed_count,
    output logic [15:0] ref_count
);
    import rcst_pkg::*;

    logic clearing;
    logic q_push_valid, q_push_ready;
    logic q_pop_valid, q_pop_ready;
    op_t  q_push_op, q_pop_op;

    rcst_front #(
        .SLOTS (SLOTS)
    ) u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .slot_a   (slot_a),
        .slot_b   (slot_b),
        .clearing (clearing),
        .q_valid  (q_push_valid),
        .q_ready  (q_push_ready),
        .q_op     (q_push_op)
    );

    rcst_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_op),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_op)
    );

    rcst_back #(
        .SLOTS      (SLOTS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .op_valid    (q_pop_valid),
        .op_ready    (q_pop_ready),
        .op          (q_pop_op),
        .clearing    (clearing),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .slot_index  (slot_index),
        .freed_count (freed_count),
        .ref_count   (ref_count)
    );

endmodule

// ===== design/rcst_queue.sv =====
// ============================================================================
// rcst_queue
// two-entry request queue between the front and the back
// ============================================================================
module rcst_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  rcst_pkg::op_t    push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output rcst_pkg::op_t    pop_data
);
    import rcst_pkg::*;

    localparam logic [1:0] FULL_COUNT = 2'd2;

    op_t        buf_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign push_ready = (count_reg != FULL_COUNT);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = buf_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== design/rcst_front.sv =====
// ============================================================================
// rcst_front
// takes requests, range-checks the slot fields and forms a classified request
// ============================================================================
module rcst_front
#(
    parameter int SLOTS = 64
)
(
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       cmd,
    input  logic [6:0]       slot_a,
    input  logic [6:0]       slot_b,
    input  logic             clearing,
    output logic             q_valid,
    input  logic             q_ready,
    output rcst_pkg::op_t    q_op
);
    import rcst_pkg::*;

    // nothing is taken while the table is being cleared
    assign in_ready = q_ready && !clearing;
    assign q_valid  = in_valid && !clearing;

    always_comb
    begin
        q_op.cmd    = cmd;
        q_op.a_ok   = (32'(slot_a) < SLOTS);
        q_op.b_ok   = (32'(slot_b) < SLOTS);
        q_op.slot_a = slot_a;
        q_op.slot_b = slot_b;
    end

endmodule

// ===== design/rcst_back.sv =====
// ============================================================================
// rcst_back
// executes requests against the slot memory: allocation scan, add, link and
// release cascade, then holds the result in the output register
// ============================================================================
module rcst_back
#(
    parameter int SLOTS      = 64,
    parameter int COUNT_BITS = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             op_valid,
    output logic             op_ready,
    input  rcst_pkg::op_t    op,
    output logic             clearing,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [2:0]       status,
    output logic [5:0]       slot_index,
    output logic [6:0]       freed_count,
    output logic [15:0]      ref_count
);
    import rcst_pkg::*;

    localparam int SW = $clog2(SLOTS);
    localparam int FW = $clog2(SLOTS + 1);
    localparam logic [SW-1:0]         LAST      = SW'(SLOTS - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic                  used;
        logic                  pv;
        logic [SW-1:0]         parent;
        logic [COUNT_BITS-1:0] refs;
    } entry_t;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_A     = 8'b0000_0100,
        S_B     = 8'b0000_1000,
        S_LINK2 = 8'b0001_0000,
        S_REL   = 8'b0010_0000,
        S_SCAN  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t                state_reg, state_next;
    entry_t                mem [SLOTS];
    entry_t                rdata_reg;
    logic                  we;
    logic [SW-1:0]         waddr, raddr;
    entry_t                wdata;

    op_t                   op_reg, op_next;
    logic [SW-1:0]         idx_reg, idx_next;
    entry_t                ent_reg, ent_next;
    logic [FW-1:0]         freed_reg, freed_next;
    logic [2:0]            res_status_reg, res_status_next;
    logic [SW-1:0]         res_slot_reg, res_slot_next;
    logic [COUNT_BITS-1:0] res_refs_reg, res_refs_next;

    logic                  out_valid_reg, out_valid_next;
    logic [2:0]            status_reg, status_next;
    logic [5:0]            slot_index_reg, slot_index_next;
    logic [6:0]            freed_count_reg, freed_count_next;
    logic [15:0]           ref_count_reg, ref_count_next;

    logic [SW-1:0]         a_idx, b_idx, cur;
    logic [COUNT_BITS-1:0] dec;
    logic                  do_step;

    assign a_idx       = SW'(op_reg.slot_a);
    assign b_idx       = SW'(op_reg.slot_b);
    assign clearing    = (state_reg == S_CLEAR);
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign slot_index  = slot_index_reg;
    assign freed_count = freed_count_reg;
    assign ref_count   = ref_count_reg;

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        idx_next         = idx_reg;
        ent_next         = ent_reg;
        freed_next       = freed_reg;
        res_status_next  = res_status_reg;
        res_slot_next    = res_slot_reg;
        res_refs_next    = res_refs_reg;
        out_valid_next   = out_valid_reg;
        status_next      = status_reg;
        slot_index_next  = slot_index_reg;
        freed_count_next = freed_count_reg;
        ref_count_next   = ref_count_reg;
        we               = 1'b0;
        waddr            = idx_reg;
        wdata            = '0;
        raddr            = idx_reg;
        op_ready         = 1'b0;
        do_step          = 1'b0;
        cur              = (state_reg == S_A) ? a_idx : idx_reg;
        dec              = rdata_reg.refs - COUNT_BITS'(1);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                we       = 1'b1;
                waddr    = idx_reg;
                idx_next = idx_reg + SW'(1);
                if (idx_reg == LAST)
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                op_ready = 1'b1;
                if (op_valid)
                begin
                    op_next    = op;
                    freed_next = '0;
                    if (op.cmd == CMD_ALLOC)
                    begin
                        idx_next   = '0;
                        raddr      = '0;
                        state_next = S_SCAN;
                    end
                    else if (!op.a_ok)
                    begin
                        res_status_next = ST_RANGE;
                        res_slot_next   = '0;
                        res_refs_next   = '0;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        raddr      = SW'(op.slot_a);
                        state_next = S_A;
                    end
                end
            end
            S_SCAN:
            begin
                if (!rdata_reg.used)
                begin
                    we              = 1'b1;
                    waddr           = idx_reg;
                    wdata.used      = 1'b1;
                    res_status_next = ST_OK;
                    res_slot_next   = idx_reg;
                    res_refs_next   = '0;
                    state_next      = S_DONE;
                end
                else if (idx_reg == LAST)
                begin
                    res_status_next = ST_FULL;
                    res_slot_next   = '0;
                    res_refs_next   = '0;
                    state_next      = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + SW'(1);
                    raddr    = idx_reg + SW'(1);
                end
            end
            S_A:
            begin
                if (!rdata_reg.used)
                begin
                    res_status_next = ST_UNUSED;
                    res_slot_next   = a_idx;
                    res_refs_next   = '0;
                    state_next      = S_DONE;
                end
                else
                begin
                    case (op_reg.cmd)
                        CMD_ADD:
                        begin
                            res_slot_next = a_idx;
                            if (rdata_reg.refs == COUNT_MAX)
                            begin
                                res_status_next = ST_SAT;
                                res_refs_next   = COUNT_MAX;
                            end
                            else
                            begin
                                we              = 1'b1;
                                waddr           = a_idx;
                                wdata           = rdata_reg;
                                wdata.refs      = rdata_reg.refs + COUNT_BITS'(1);
                                res_status_next = ST_OK;
                                res_refs_next   = rdata_reg.refs + COUNT_BITS'(1);
                            end
                            state_next = S_DONE;
                        end
                        CMD_LINK:
                        begin
                            if (!op_reg.b_ok)
                            begin
                                res_status_next = ST_RANGE;
                                res_slot_next   = '0;
                                res_refs_next   = '0;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                ent_next   = rdata_reg;
                                raddr      = b_idx;
                                state_next = S_B;
                            end
                        end
                        CMD_RELEASE:
                        begin
                            res_status_next = ST_OK;
                            res_slot_next   = a_idx;
                            do_step         = 1'b1;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_B:
            begin
                if (!rdata_reg.used)
                begin
                    res_status_next = ST_UNUSED;
                    res_slot_next   = b_idx;
                    res_refs_next   = '0;
                    state_next      = S_DONE;
                end
                else if (ent_reg.refs == COUNT_MAX)
                begin
                    res_status_next = ST_SAT;
                    res_slot_next   = a_idx;
                    res_refs_next   = COUNT_MAX;
                    state_next      = S_DONE;
                end
                else
                begin
                    // child first; a self link folds both updates into one write
                    we           = 1'b1;
                    waddr        = b_idx;
                    wdata        = rdata_reg;
                    wdata.pv     = 1'b1;
                    wdata.parent = a_idx;
                    if (a_idx == b_idx)
                    begin
                        wdata.refs = ent_reg.refs + COUNT_BITS'(1);
                    end
                    res_status_next = ST_OK;
                    res_slot_next   = a_idx;
                    res_refs_next   = ent_reg.refs + COUNT_BITS'(1);
                    state_next      = (a_idx == b_idx) ? S_DONE : S_LINK2;
                end
            end
            S_LINK2:
            begin
                we         = 1'b1;
                waddr      = a_idx;
                wdata      = ent_reg;
                wdata.refs = ent_reg.refs + COUNT_BITS'(1);
                state_next = S_DONE;
            end
            S_REL:
            begin
                do_step = 1'b1;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    status_next      = res_status_reg;
                    slot_index_next  = 6'(res_slot_reg);
                    freed_count_next = 7'(freed_reg);
                    ref_count_next   = 16'(res_refs_reg);
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // one link of the release chain, rdata_reg holds slot cur
        if (do_step)
        begin
            state_next = S_DONE;
            waddr      = cur;
            if (!rdata_reg.used)
            begin
                we = 1'b0;
            end
            else if (rdata_reg.refs == '0)
            begin
                we         = 1'b1;
                freed_next = freed_reg + FW'(1);
                if (state_reg == S_A)
                begin
                    res_refs_next = '0;
                end
            end
            else if (dec != '0)
            begin
                we         = 1'b1;
                wdata      = rdata_reg;
                wdata.refs = dec;
                if (state_reg == S_A)
                begin
                    res_refs_next = dec;
                end
            end
            else
            begin
                we         = 1'b1;
                freed_next = freed_reg + FW'(1);
                if (state_reg == S_A)
                begin
                    res_refs_next = '0;
                end
                // a slot linked to itself is already free once written
                if (rdata_reg.pv && (rdata_reg.parent != cur))
                begin
                    idx_next   = rdata_reg.parent;
                    raddr      = rdata_reg.parent;
                    state_next = S_REL;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        ent_reg         <= ent_next;
        freed_reg       <= freed_next;
        res_status_reg  <= res_status_next;
        res_slot_reg    <= res_slot_next;
        res_refs_reg    <= res_refs_next;
        status_reg      <= status_next;
        slot_index_reg  <= slot_index_next;
        freed_count_reg <= freed_count_next;
        ref_count_reg   <= ref_count_next;
    end

    // slot memory, read data registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

endmodule

// ===== design/rcst_checker.sv =====
// ============================================================================
// rcst_checker
// port-level checks on the slot table results, bound to the top level
// ============================================================================
`include "refcounted_slot_table_assert.svh"

module rcst_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [5:0]  slot_index,
    input logic [6:0]  freed_count,
    input logic [15:0] ref_count
);
    import rcst_pkg::*;

    logic        out_stall;
    logic        status_known;
    logic        range_or_full;
    logic [31:0] result_bits;

    assign out_stall     = out_valid && !out_ready;
    assign status_known  = (status == ST_OK) || (status == ST_RANGE) ||
                           (status == ST_UNUSED) || (status == ST_FULL) ||
                           (status == ST_SAT);
    assign range_or_full = (status == ST_RANGE) || (status == ST_FULL);
    assign result_bits   = {status, slot_index, freed_count, ref_count};

    // a stalled result holds
    `RCST_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(result_bits))

    // only known status codes
    `RCST_ASSERT_IMPL(a_status_code, out_valid, status_known)

    // a result with an error status frees no slots
    `RCST_ASSERT_IMPL(a_freed_ok, out_valid && status != ST_OK, freed_count == 7'd0)

    // range and full errors carry no slot and no count
    `RCST_ASSERT_IMPL(a_err_empty, out_valid && range_or_full, slot_index == 6'd0 && ref_count == 16'd0)

endmodule

bind refcounted_slot_table rcst_checker u_checker (.*);

// ===== sim/tb.sv =====
// ============================================================================
// tb
// self-checking bench for refcounted_slot_table: directed and random
// requests, random gaps and output stalls, every result checked against a
// slot model
module tb;

    import rcst_pkg::*;

    localparam int              NSLOTS    = 64;
    localparam logic [15:0]     COUNT_TOP = 16'hFFFF;
    localparam int              IDLE_PCT  = 29;
    localparam int              RAND_REQS = 740;

    typedef struct {
        logic [1:0] op;
        logic [6:0] a;
        logic [6:0] b;
    } request_t;

    typedef struct {
        logic [2:0]  status;
        logic [5:0]  slot;
        logic [6:0]  freed;
        logic [15:0] refs;
    } reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  cmd = CMD_ALLOC;
    logic [6:0]  slot_a = 7'd0;
    logic [6:0]  slot_b = 7'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic [5:0]  slot_index;
    logic [6:0]  freed_count;
    logic [15:0] ref_count;

    request_t    request_q[$];
    reply_t      replies_due[$];
    request_t    drv_req;
    bit          steady = 1'b0;
    int          mismatches = 0;

    bit          in_use[NSLOTS];
    logic [15:0] refs[NSLOTS];
    bit          has_parent[NSLOTS];
    logic [5:0]  parent_of[NSLOTS];

    logic [5:0]  fresh[$];
    logic [5:0]  busy[$];

    refcounted_slot_table i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .slot_a      (slot_a),
        .slot_b      (slot_b),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .slot_index  (slot_index),
        .freed_count (freed_count),
        .ref_count   (ref_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= 20)
            $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
    endtask

    task automatic clear_slot(input logic [5:0] s);
        in_use[s]     = 1'b0;
        refs[s]       = 16'd0;
        has_parent[s] = 1'b0;
        parent_of[s]  = 6'd0;
    endtask

    task automatic step_table(input logic [1:0] op, input logic [6:0] a,
                              input logic [6:0] b);
        reply_t     r;
        int         idx;
        int         step;
        int         freed;
        logic [6:0] cur;
        logic [5:0] up;
        bit         go_on;
        r = '{ST_OK, 6'd0, 7'd0, 16'd0};
        if (op == CMD_ALLOC)
        begin
            r.status = ST_FULL;
            for (idx = 0; idx < NSLOTS; idx++)
            begin
                if (!in_use[idx])
                begin
                    clear_slot(idx[5:0]);
                    in_use[idx] = 1'b1;
                    r.status = ST_OK;
                    r.slot = idx[5:0];
                    break;
                end
            end
        end
        else if (a >= NSLOTS)
            r.status = ST_RANGE;
        else if (!in_use[a[5:0]])
        begin
            r.status = ST_UNUSED;
            r.slot = a[5:0];
        end
        else if (op == CMD_ADD)
        begin
            r.slot = a[5:0];
            if (refs[a[5:0]] == COUNT_TOP)
                r.status = ST_SAT;
            else
                refs[a[5:0]]++;
            r.refs = refs[a[5:0]];
        end
        else if (op == CMD_LINK)
        begin
            if (b >= NSLOTS)
                r.status = ST_RANGE;
            else if (!in_use[b[5:0]])
            begin
                r.status = ST_UNUSED;
                r.slot = b[5:0];
            end
            else
            begin
                r.slot = a[5:0];
                if (refs[a[5:0]] == COUNT_TOP)
                    r.status = ST_SAT;
                else
                begin
                    refs[a[5:0]]++;
                    has_parent[b[5:0]] = 1'b1;
                    parent_of[b[5:0]] = a[5:0];
                end
                r.refs = refs[a[5:0]];
            end
        end
        else
        begin
            // release, walking up the parent chain
            cur = a;
            freed = 0;
            for (step = 0; step < NSLOTS; step++)
            begin
                if (cur >= NSLOTS || !in_use[cur[5:0]])
                    break;
                if (refs[cur[5:0]] == 16'd0)
                begin
                    clear_slot(cur[5:0]);
                    freed++;
                    break;
                end
                refs[cur[5:0]]--;
                if (refs[cur[5:0]] != 16'd0)
                    break;
                go_on = has_parent[cur[5:0]];
                up = parent_of[cur[5:0]];
                clear_slot(cur[5:0]);
                freed++;
                if (!go_on)
                    break;
                cur = {1'b0, up};
            end
            r.slot = a[5:0];
            r.freed = freed[6:0];
            r.refs = in_use[a[5:0]] ? refs[a[5:0]] : 16'd0;
        end
        replies_due.push_back(r);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cmd      <= CMD_ALLOC;
            slot_a   <= 7'd0;
            slot_b   <= 7'd0;
        end
        else
        begin
            if (in_valid && in_ready)
                step_table(cmd, slot_a, slot_b);
            if (!in_valid || in_ready)
            begin
                if (request_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
                begin
                    drv_req = request_q.pop_front();
                    in_valid <= 1'b1;
                    cmd      <= drv_req.op;
                    slot_a   <= drv_req.a;
                    slot_b   <= drv_req.b;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (replies_due.size() == 0)
                    flag_mismatch("result with none outstanding, status", int'(status), 0);
                else
                begin
                    if (status != replies_due[0].status)
                        flag_mismatch("status", int'(status),
                                      int'(replies_due[0].status));
                    if (slot_index != replies_due[0].slot)
                        flag_mismatch("slot_index", int'(slot_index),
                                      int'(replies_due[0].slot));
                    if (freed_count != replies_due[0].freed)
                        flag_mismatch("freed_count", int'(freed_count),
                                      int'(replies_due[0].freed));
                    if (ref_count != replies_due[0].refs)
                        flag_mismatch("ref_count", int'(ref_count),
                                      int'(replies_due[0].refs));
                    void'(replies_due.pop_front());
                end
            end
            out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic push_request(input logic [1:0] op, input logic [6:0] a,
                                input logic [6:0] b);
        request_t q;
        q.op = op;
        q.a  = a;
        q.b  = b;
        request_q.push_back(q);
    endtask

    task automatic drain();
        @(negedge clk);
        while (request_q.size() != 0 || replies_due.size() != 0 || in_valid)
            @(negedge clk);
    endtask

    task automatic survey_table();
        int s;
        fresh.delete();
        busy.delete();
        for (s = 0; s < NSLOTS; s++)
        begin
            if (in_use[s])
                busy.push_back(s[5:0]);
            else
                fresh.push_back(s[5:0]);
        end
    endtask

    function automatic logic [6:0] rand_slot();
        return 7'($urandom_range(127));
    endfunction

    function automatic logic [6:0] pick_slot();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70 && busy.size() != 0)
            return {1'b0, busy[$urandom_range(busy.size() - 1)]};
        else if (roll < 85)
            return 7'($urandom_range(63));
        else
            return 7'($urandom_range(127, 64));
    endfunction

    initial
    begin
        int i;
        int k;
        int n;
        int made;
        int burst;
        int roll;
        logic [1:0] op;

        for (i = 0; i < NSLOTS; i++)
            clear_slot(i[5:0]);

        // short chain released from the bottom, then the error paths
        push_request(CMD_ALLOC, 7'd0, 7'd0);
        push_request(CMD_ALLOC, 7'd127, 7'd127);
        push_request(CMD_ALLOC, 7'd64, 7'd63);
        push_request(CMD_ADD, 7'd2, 7'd0);
        push_request(CMD_LINK, 7'd0, 7'd1);
        push_request(CMD_LINK, 7'd1, 7'd2);
        push_request(CMD_RELEASE, 7'd2, 7'd0);
        push_request(CMD_ADD, 7'd64, 7'd0);
        push_request(CMD_RELEASE, 7'd127, 7'd127);
        push_request(CMD_ADD, 7'd5, 7'd0);
        push_request(CMD_ALLOC, 7'd0, 7'd0);
        push_request(CMD_LINK, 7'd0, 7'd127);
        push_request(CMD_LINK, 7'd0, 7'd63);
        push_request(CMD_LINK, 7'd127, 7'd0);
        // self link, then relink to a new parent
        push_request(CMD_LINK, 7'd0, 7'd0);
        push_request(CMD_ALLOC, 7'd0, 7'd0);
        push_request(CMD_LINK, 7'd1, 7'd0);
        push_request(CMD_RELEASE, 7'd1, 7'd0);
        push_request(CMD_RELEASE, 7'd0, 7'd0);
        // release at count zero keeps the parent count
        push_request(CMD_ALLOC, 7'd0, 7'd0);
        push_request(CMD_ALLOC, 7'd0, 7'd0);
        push_request(CMD_LINK, 7'd0, 7'd1);
        push_request(CMD_RELEASE, 7'd1, 7'd0);
        push_request(CMD_RELEASE, 7'd0, 7'd0);
        push_request(CMD_RELEASE, 7'd63, 7'd0);
        push_request(CMD_LINK, 7'd63, 7'd63);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // fill the table, one more allocate, then one chain across every slot
        drain();
        survey_table();
        for (i = 0; i <= fresh.size(); i++)
            push_request(CMD_ALLOC, rand_slot(), rand_slot());
        for (i = 0; i + 1 < fresh.size(); i++)
            push_request(CMD_LINK, {1'b0, fresh[i]}, {1'b0, fresh[i + 1]});
        if (fresh.size() != 0)
        begin
            push_request(CMD_ADD, {1'b0, fresh[fresh.size() - 1]}, 7'd0);
            push_request(CMD_RELEASE, {1'b0, fresh[fresh.size() - 1]}, 7'd0);
        end

        made = 0;
        burst = 0;
        while (made < RAND_REQS)
        begin
            drain();
            survey_table();
            steady = (burst >= 20 && burst < 28);
            if ($urandom_range(1) == 0 && fresh.size() >= 2)
            begin
                // well-formed chain with random extras
                k = $urandom_range(10, 2);
                if ($urandom_range(9) == 0)
                    k = $urandom_range(40, 11);
                if (k > fresh.size())
                    k = fresh.size();
                for (i = 0; i < k; i++)
                    push_request(CMD_ALLOC, rand_slot(), rand_slot());
                for (i = 0; i + 1 < k; i++)
                    push_request(CMD_LINK, {1'b0, fresh[i]}, {1'b0, fresh[i + 1]});
                n = 2 * k;
                for (i = 0; i < k; i++)
                begin
                    if ($urandom_range(5) == 0)
                    begin
                        push_request(CMD_ADD, {1'b0, fresh[i]}, rand_slot());
                        n++;
                    end
                end
                push_request(CMD_ADD, {1'b0, fresh[k - 1]}, rand_slot());
                push_request(CMD_RELEASE, {1'b0, fresh[k - 1]}, rand_slot());
                push_request(CMD_RELEASE, pick_slot(), rand_slot());
                push_request(2'($urandom_range(3)), pick_slot(), pick_slot());
                made += n + 3;
            end
            else
            begin
                for (i = 0; i < 16; i++)
                begin
                    roll = $urandom_range(99);
                    op = (roll < 20) ? CMD_ALLOC :
                         (roll < 50) ? CMD_ADD :
                         (roll < 85) ? CMD_RELEASE : CMD_LINK;
                    push_request(op, pick_slot(),
                                 (op == CMD_LINK) ? pick_slot() : rand_slot());
                end
                made += 16;
            end
            burst++;
        end

        drain();
        steady = 1'b0;
        repeat (NSLOTS + 16) @(posedge clk);
        if (replies_due.size() != 0)
            flag_mismatch("results never returned", replies_due.size(), 0);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #30000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/rcst_pkg.sv
design/rcst_queue.sv
design/rcst_front.sv
design/rcst_back.sv
design/refcounted_slot_table.sv
design/rcst_checker.sv
sim/tb.sv
